>>> rtl/nite_pkg.sv
// Package for the NDN Interest TLV encoder: opcodes, status codes, TLV types, varnum helpers.
// No dependencies.
package nite_pkg;
    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_FINISH = 2'd1,
        OP_PULL = 2'd2,
        OP_NONE = 2'd3
    } t_opcode;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_NAME_FULL = 2'd1;
    localparam logic [1:0] ST_TABLE_FULL = 2'd2;
    localparam logic [1:0] ST_BAD = 2'd3;

    localparam logic [7:0] SEPARATOR = 8'h2f;
    localparam logic [7:0] TYPE_INTEREST = 8'h05;
    localparam logic [7:0] TYPE_NAME = 8'h07;
    localparam logic [7:0] TYPE_COMPONENT = 8'h08;
    localparam logic [7:0] TYPE_NONCE = 8'h0a;
    localparam logic [7:0] NONCE_LEN = 8'h04;

    function automatic logic [2:0] varnum_size(input logic [31:0] v);
        if (v < 32'd253) return 3'd1;
        if (v <= 32'h0000ffff) return 3'd3;
        return 3'd5;
    endfunction

    function automatic logic [7:0] varnum_byte(input logic [31:0] v, input logic [2:0] idx);
        logic [2:0] s;
        s = varnum_size(v);
        if (s == 3'd1) return v[7:0];
        if (idx == 3'd0) return (s == 3'd3) ? 8'd253 : 8'd254;
        if (s == 3'd3) return (idx == 3'd1) ? v[15:8] : v[7:0];
        unique case (idx)
            3'd1: return v[31:24];
            3'd2: return v[23:16];
            3'd3: return v[15:8];
            default: return v[7:0];
        endcase
    endfunction
endpackage

>>> rtl/ndn_interest_tlv_encoder_core.sv
// NDN Interest encoder top level: loader, emitter sequencer, two stores.
// Depends on nite_pkg and nite_mem.
//
// Usage: each input word carries an opcode. Push adds a name character
// ('/' closes a component), finish closes the name and latches the nonce,
// pull returns the next packet byte. Every accepted word yields exactly one
// output word with valid/byte/last/status.
// Timing: a push or finish result is registered at the accepting edge and
// offered the next cycle. A pull launches the store reads at the accepting
// edge; the read data is used in the following cycle, when the result is
// registered and then offered from the output register.
// The input is stalled while a word is in flight or its result waits, so no
// new word is taken before the previous result is delivered.
// Reset: all counters clear and the block returns to loading; store contents
// stay undefined until written.
// Output stall: the result is held in the output register and no new input
// word is taken until it is delivered.
module ndn_interest_tlv_encoder_core #(
    parameter int NAME_BYTES = 256,
    parameter int MAX_COMPONENTS = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_opcode,
    input  logic [7:0] i_name_byte,
    input  logic [31:0] i_nonce,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_out_valid,
    output logic [7:0] o_out_byte,
    output logic       o_out_last,
    output logic [1:0] o_status
);
    import nite_pkg::*;

    localparam int NW = $clog2(NAME_BYTES);
    localparam int CW = $clog2(MAX_COMPONENTS);
    localparam int NCW = $clog2(NAME_BYTES + 1);
    localparam int KCW = $clog2(MAX_COMPONENTS + 1);

    typedef enum logic [3:0] {
        PH_LOAD, PH_OUTER_TYPE, PH_OUTER_LEN, PH_NAME_TYPE, PH_NAME_LEN,
        PH_COMP_TYPE, PH_COMP_LEN, PH_COMP_DATA, PH_NONCE_TYPE, PH_NONCE_LEN,
        PH_NONCE_DATA
    } t_phase;

    t_phase        r_phase;
    logic [NCW-1:0] r_name_count;
    logic [KCW-1:0] r_comp_count;
    logic [NCW-1:0] r_cur_len;
    logic [31:0]   r_sum;
    logic [31:0]   r_nonce;
    logic [15:0]   r_pos;
    logic [KCW-1:0] r_emit_comp;
    logic [NCW-1:0] r_store_rd;
    logic          r_busy;
    logic          r_pull;
    logic          r_out_pend;

    logic [7:0]    w_name_rd;
    logic [NCW-1:0] w_len_rd;
    logic          w_accept;
    logic          w_name_we;
    logic          w_len_we;
    logic          w_sep;

    assign o_stall = r_busy | r_out_pend;
    assign w_accept = i_valid & ~o_stall;
    assign w_sep = (i_name_byte == SEPARATOR);
    assign w_name_we = w_accept && i_opcode == OP_PUSH && r_phase == PH_LOAD && !w_sep
        && r_name_count < NCW'(NAME_BYTES);
    assign w_len_we = w_accept && r_phase == PH_LOAD && r_comp_count < KCW'(MAX_COMPONENTS)
        && ((i_opcode == OP_PUSH && w_sep
             && 32'(r_comp_count) + 32'd1 < 32'(MAX_COMPONENTS))
            || i_opcode == OP_FINISH);

    nite_mem #(.DEPTH(NAME_BYTES), .WIDTH(8)) u_name (
        .i_clk(i_clk), .i_we(w_name_we), .i_waddr(r_name_count[NW-1:0]),
        .i_wdata(i_name_byte), .i_raddr(r_store_rd[NW-1:0]), .o_rdata(w_name_rd)
    );
    nite_mem #(.DEPTH(MAX_COMPONENTS), .WIDTH(NCW)) u_len (
        .i_clk(i_clk), .i_we(w_len_we), .i_waddr(r_comp_count[CW-1:0]),
        .i_wdata(r_cur_len), .i_raddr(r_emit_comp[CW-1:0]), .o_rdata(w_len_rd)
    );

    logic [31:0] w_total;
    logic [31:0] w_clen;
    logic [31:0] w_add;
    assign w_total = 32'd7 + 32'(varnum_size(r_sum)) + r_sum;
    assign w_clen = (r_emit_comp < KCW'(MAX_COMPONENTS)) ? 32'(w_len_rd) : 32'd0;
    assign w_add = 32'd1 + 32'(varnum_size(32'(r_cur_len))) + 32'(r_cur_len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LOAD;
            r_name_count <= '0;
            r_comp_count <= '0;
            r_cur_len <= '0;
            r_sum <= '0;
            r_nonce <= '0;
            r_pos <= '0;
            r_emit_comp <= '0;
            r_store_rd <= '0;
            r_busy <= 1'b0;
            r_pull <= 1'b0;
            r_out_pend <= 1'b0;
            o_out_valid <= 1'b0;
            o_out_byte <= '0;
            o_out_last <= 1'b0;
            o_status <= ST_OK;
        end else begin
            if (r_out_pend && !i_stall) begin
                r_out_pend <= 1'b0;
            end
            if (w_accept) begin
                o_out_valid <= 1'b0;
                o_out_byte <= '0;
                o_out_last <= 1'b0;
                o_status <= ST_OK;
                if (i_opcode == OP_PULL && r_phase != PH_LOAD) begin
                    r_busy <= 1'b1;
                    r_pull <= 1'b1;
                end else begin
                    r_out_pend <= 1'b1;
                    if (i_opcode == OP_PUSH && r_phase == PH_LOAD) begin
                        if (w_sep) begin
                            if (32'(r_comp_count) + 32'd1 < 32'(MAX_COMPONENTS)) begin
                                r_comp_count <= r_comp_count + 1'b1;
                                r_sum <= r_sum + w_add;
                                r_cur_len <= '0;
                            end else begin
                                o_status <= ST_TABLE_FULL;
                            end
                        end else if (r_name_count < NCW'(NAME_BYTES)) begin
                            r_name_count <= r_name_count + 1'b1;
                            r_cur_len <= r_cur_len + 1'b1;
                        end else begin
                            o_status <= ST_NAME_FULL;
                        end
                    end else if (i_opcode == OP_FINISH && r_phase == PH_LOAD) begin
                        r_comp_count <= r_comp_count + 1'b1;
                        r_sum <= r_sum + w_add;
                        r_cur_len <= '0;
                        r_nonce <= i_nonce;
                        r_phase <= PH_OUTER_TYPE;
                        r_pos <= '0;
                        r_emit_comp <= '0;
                        r_store_rd <= '0;
                    end else begin
                        o_status <= ST_BAD;
                    end
                end
            end
            if (r_pull) begin
                r_pull <= 1'b0;
                r_busy <= 1'b0;
                r_out_pend <= 1'b1;
                o_out_valid <= 1'b1;
                unique case (r_phase)
                    PH_OUTER_TYPE: begin
                        o_out_byte <= TYPE_INTEREST;
                        r_phase <= PH_OUTER_LEN;
                        r_pos <= '0;
                    end
                    PH_OUTER_LEN: begin
                        o_out_byte <= varnum_byte(w_total, r_pos[2:0]);
                        r_pos <= r_pos + 1'b1;
                        if (r_pos + 16'd1 >= 16'(varnum_size(w_total))) begin
                            r_phase <= PH_NAME_TYPE;
                            r_pos <= '0;
                        end
                    end
                    PH_NAME_TYPE: begin
                        o_out_byte <= TYPE_NAME;
                        r_phase <= PH_NAME_LEN;
                        r_pos <= '0;
                    end
                    PH_NAME_LEN: begin
                        o_out_byte <= varnum_byte(r_sum, r_pos[2:0]);
                        r_pos <= r_pos + 1'b1;
                        if (r_pos + 16'd1 >= 16'(varnum_size(r_sum))) begin
                            r_pos <= '0;
                            r_emit_comp <= '0;
                            r_store_rd <= '0;
                            r_phase <= (r_comp_count != '0) ? PH_COMP_TYPE : PH_NONCE_TYPE;
                        end
                    end
                    PH_COMP_TYPE: begin
                        o_out_byte <= TYPE_COMPONENT;
                        r_phase <= PH_COMP_LEN;
                        r_pos <= '0;
                    end
                    PH_COMP_LEN: begin
                        o_out_byte <= varnum_byte(w_clen, r_pos[2:0]);
                        r_pos <= r_pos + 1'b1;
                        if (r_pos + 16'd1 >= 16'(varnum_size(w_clen))) begin
                            r_pos <= '0;
                            if (w_clen == 32'd0) begin
                                r_emit_comp <= r_emit_comp + 1'b1;
                                r_phase <= (r_emit_comp + 1'b1 < r_comp_count)
                                    ? PH_COMP_TYPE : PH_NONCE_TYPE;
                            end else begin
                                r_phase <= PH_COMP_DATA;
                            end
                        end
                    end
                    PH_COMP_DATA: begin
                        o_out_byte <= (r_store_rd < NCW'(NAME_BYTES)) ? w_name_rd : 8'd0;
                        r_store_rd <= r_store_rd + 1'b1;
                        r_pos <= r_pos + 1'b1;
                        if (32'(r_pos) + 32'd1 >= w_clen) begin
                            r_pos <= '0;
                            r_emit_comp <= r_emit_comp + 1'b1;
                            r_phase <= (r_emit_comp + 1'b1 < r_comp_count)
                                ? PH_COMP_TYPE : PH_NONCE_TYPE;
                        end
                    end
                    PH_NONCE_TYPE: begin
                        o_out_byte <= TYPE_NONCE;
                        r_phase <= PH_NONCE_LEN;
                    end
                    PH_NONCE_LEN: begin
                        o_out_byte <= NONCE_LEN;
                        r_phase <= PH_NONCE_DATA;
                        r_pos <= '0;
                    end
                    default: begin
                        unique case (r_pos[1:0])
                            2'd0: o_out_byte <= r_nonce[31:24];
                            2'd1: o_out_byte <= r_nonce[23:16];
                            2'd2: o_out_byte <= r_nonce[15:8];
                            default: o_out_byte <= r_nonce[7:0];
                        endcase
                        r_pos <= r_pos + 1'b1;
                        if (r_pos + 16'd1 >= 16'd4) begin
                            o_out_last <= 1'b1;
                            r_phase <= PH_LOAD;
                            r_pos <= '0;
                            r_emit_comp <= '0;
                            r_store_rd <= '0;
                            r_name_count <= '0;
                            r_comp_count <= '0;
                            r_cur_len <= '0;
                            r_sum <= '0;
                        end
                    end
                endcase
            end
        end
    end

    assign o_valid = r_out_pend;

    property p_no_accept_busy;
        @(posedge i_clk) disable iff (!i_rst_n) r_busy |-> !w_accept;
    endproperty
    a_no_accept_busy: assert property (p_no_accept_busy) else $error("accept while busy");

    property p_pull_result;
        @(posedge i_clk) disable iff (!i_rst_n) r_pull |=> (r_out_pend && o_out_valid);
    endproperty
    a_pull_result: assert property (p_pull_result) else $error("pull lost result");

    property p_last_load;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_out_pend && o_out_last) |-> r_phase == PH_LOAD;
    endproperty
    a_last_load: assert property (p_last_load) else $error("last without reload");
endmodule

>>> rtl/nite_mem.sv
// Synchronous single-port-write, single-read memory with registered read data.
// Depends on nothing.
module nite_mem #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> tb/sv/interest_byte_check.sv
// Channel monitor for the NDN Interest encoder: predicts each result word
// from the accepted input words and compares it field by field.
// Depends on nite_pkg.
module interest_byte_check #(
    parameter int NAME_BYTES = 256,
    parameter int MAX_COMPONENTS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_stall_in,
    input  logic [1:0]  i_opcode,
    input  logic [7:0]  i_name_byte,
    input  logic [31:0] i_nonce,
    input  logic        i_out_word_valid,
    input  logic        i_stall_out,
    input  logic        i_out_valid,
    input  logic [7:0]  i_out_byte,
    input  logic        i_out_last,
    input  logic [1:0]  i_status,
    output int          o_fails,
    output int          o_pending
);
    import nite_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [3:0] {
        PH_LOAD, PH_OUTER_TYPE, PH_OUTER_LEN, PH_NAME_TYPE, PH_NAME_LEN,
        PH_COMP_TYPE, PH_COMP_LEN, PH_COMP_DATA, PH_NONCE_TYPE, PH_NONCE_LEN,
        PH_NONCE_DATA
    } t_phase;

    typedef struct packed {
        logic       pkt_valid;
        logic [7:0] pkt_byte;
        logic       pkt_last;
        logic [1:0] status;
    } t_word;

    logic [7:0]  chars [NAME_BYTES];
    logic [8:0]  comp_len [MAX_COMPONENTS];
    int unsigned char_cnt, comp_cnt, cur_len, name_sum, emit_pos, emit_comp, rd_ptr;
    logic [31:0] nonce_q;
    t_phase      phase;
    t_word       expected_words [$];

    initial o_fails = 0;
    assign o_pending = expected_words.size();

    function automatic int unsigned vn_size(logic [31:0] v);
        if (v < 253) return 1;
        if (v <= 32'hffff) return 3;
        return 5;
    endfunction

    function automatic logic [7:0] vn_byte(logic [31:0] v, int unsigned idx);
        int unsigned s;
        s = vn_size(v);
        if (s == 1) return v[7:0];
        if (idx == 0) return (s == 3) ? 8'd253 : 8'd254;
        return 8'(v >> ((s - 1 - idx) * 8));
    endfunction

    function automatic void close_component();
        if (comp_cnt < MAX_COMPONENTS) comp_len[comp_cnt] = 9'(cur_len);
        comp_cnt++;
        name_sum += 1 + vn_size(cur_len) + cur_len;
        cur_len = 0;
    endfunction

    function automatic void clear_name();
        phase = PH_LOAD;
        emit_pos = 0;
        emit_comp = 0;
        rd_ptr = 0;
        char_cnt = 0;
        comp_cnt = 0;
        cur_len = 0;
        name_sum = 0;
    endfunction

    function automatic void step_component();
        emit_comp++;
        emit_pos = 0;
        phase = (emit_comp < comp_cnt) ? PH_COMP_TYPE : PH_NONCE_TYPE;
    endfunction

    function automatic t_word encode_word(t_opcode op, logic [7:0] nb, logic [31:0] nn);
        t_word r;
        logic [31:0] total;
        int unsigned len;
        r = '0;
        case (op)
            OP_PUSH: begin
                if (phase != PH_LOAD) r.status = ST_BAD;
                else if (nb == SEPARATOR) begin
                    if (comp_cnt + 1 < MAX_COMPONENTS) close_component();
                    else r.status = ST_TABLE_FULL;
                end else if (char_cnt < NAME_BYTES) begin
                    chars[char_cnt] = nb;
                    char_cnt++;
                    cur_len++;
                end else r.status = ST_NAME_FULL;
            end
            OP_FINISH: begin
                if (phase != PH_LOAD) r.status = ST_BAD;
                else begin
                    close_component();
                    nonce_q = nn;
                    phase = PH_OUTER_TYPE;
                    emit_pos = 0;
                    emit_comp = 0;
                    rd_ptr = 0;
                end
            end
            OP_PULL: begin
                if (phase == PH_LOAD) r.status = ST_BAD;
                else begin
                    total = 1 + vn_size(name_sum) + name_sum + 6;
                    r.pkt_valid = 1'b1;
                    case (phase)
                        PH_OUTER_TYPE: begin
                            r.pkt_byte = TYPE_INTEREST;
                            phase = PH_OUTER_LEN;
                            emit_pos = 0;
                        end
                        PH_OUTER_LEN: begin
                            r.pkt_byte = vn_byte(total, emit_pos);
                            emit_pos++;
                            if (emit_pos >= vn_size(total)) begin
                                phase = PH_NAME_TYPE;
                                emit_pos = 0;
                            end
                        end
                        PH_NAME_TYPE: begin
                            r.pkt_byte = TYPE_NAME;
                            phase = PH_NAME_LEN;
                            emit_pos = 0;
                        end
                        PH_NAME_LEN: begin
                            r.pkt_byte = vn_byte(name_sum, emit_pos);
                            emit_pos++;
                            if (emit_pos >= vn_size(name_sum)) begin
                                emit_pos = 0;
                                emit_comp = 0;
                                rd_ptr = 0;
                                phase = (comp_cnt > 0) ? PH_COMP_TYPE : PH_NONCE_TYPE;
                            end
                        end
                        PH_COMP_TYPE: begin
                            r.pkt_byte = TYPE_COMPONENT;
                            phase = PH_COMP_LEN;
                            emit_pos = 0;
                        end
                        PH_COMP_LEN: begin
                            len = (emit_comp < MAX_COMPONENTS) ? comp_len[emit_comp] : 0;
                            r.pkt_byte = vn_byte(len, emit_pos);
                            emit_pos++;
                            if (emit_pos >= vn_size(len)) begin
                                emit_pos = 0;
                                if (len == 0) step_component();
                                else phase = PH_COMP_DATA;
                            end
                        end
                        PH_COMP_DATA: begin
                            len = (emit_comp < MAX_COMPONENTS) ? comp_len[emit_comp] : 0;
                            r.pkt_byte = (rd_ptr < NAME_BYTES) ? chars[rd_ptr] : 8'h00;
                            rd_ptr++;
                            emit_pos++;
                            if (emit_pos >= len) step_component();
                        end
                        PH_NONCE_TYPE: begin
                            r.pkt_byte = TYPE_NONCE;
                            phase = PH_NONCE_LEN;
                        end
                        PH_NONCE_LEN: begin
                            r.pkt_byte = NONCE_LEN;
                            phase = PH_NONCE_DATA;
                            emit_pos = 0;
                        end
                        default: begin
                            r.pkt_byte = 8'(nonce_q >> ((3 - (emit_pos & 3)) * 8));
                            emit_pos++;
                            if (emit_pos >= 4) begin
                                r.pkt_last = 1'b1;
                                clear_name();
                            end
                        end
                    endcase
                end
            end
            default: r.status = ST_BAD;
        endcase
        return r;
    endfunction

    task automatic report(string field, int got, int want);
        $display("check: %s mismatch, got %0h want %0h at %0t", field, got, want, $realtime);
        o_fails++;
    endtask

    always @(posedge i_clk) begin
        t_word w;
        if (!i_rst_n) begin
            clear_name();
            nonce_q = '0;
            expected_words.delete();
        end else begin
            if (i_out_word_valid && !i_stall_out) begin
                if (expected_words.size() == 0) report("unexpected word", 0, 0);
                else begin
                    w = expected_words.pop_front();
                    if (i_out_valid !== w.pkt_valid) report("out_valid", i_out_valid, w.pkt_valid);
                    if (i_out_byte !== w.pkt_byte) report("out_byte", i_out_byte, w.pkt_byte);
                    if (i_out_last !== w.pkt_last) report("out_last", i_out_last, w.pkt_last);
                    if (i_status !== w.status) report("status", i_status, w.status);
                end
            end
            if (i_valid && !i_stall_in)
                expected_words.push_back(encode_word(t_opcode'(i_opcode), i_name_byte, i_nonce));
        end
    end
endmodule

>>> tb/sv/testbench.sv
// Top of the NDN Interest encoder testbench: clock, reset, word stimulus with
// idle/stall phases, watchdog and verdict. Depends on nite_pkg, the encoder
// core and interest_byte_check.
module testbench;
    import nite_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TARGET_WORDS = 1450;
    localparam int STALL_LIMIT = 4000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_opcode = OP_NONE;
    logic [7:0]  i_name_byte = 8'h00;
    logic [31:0] i_nonce = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_out_valid;
    logic [7:0]  o_out_byte;
    logic        o_out_last;
    logic [1:0]  o_status;
    int          fails, pending;
    int          words_sent = 0;
    int          tx_idle_pct = 0;
    int          rx_stall_pct = 0;
    int          lasts_seen = 0;
    int          quiet_cycles = 0;

    always #5 i_clk = ~i_clk;

    ndn_interest_tlv_encoder_core u_dut (.*);

    interest_byte_check u_check (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_stall_in(o_stall),
        .i_opcode(i_opcode), .i_name_byte(i_name_byte), .i_nonce(i_nonce),
        .i_out_word_valid(o_valid), .i_stall_out(i_stall), .i_out_valid(o_out_valid),
        .i_out_byte(o_out_byte), .i_out_last(o_out_last), .i_status(o_status),
        .o_fails(fails), .o_pending(pending)
    );

    always @(negedge i_clk) i_stall <= ($urandom_range(0, 99) < rx_stall_pct);

    always @(posedge i_clk) begin
        if (o_valid && !i_stall && o_out_last) lasts_seen <= lasts_seen + 1;
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send(t_opcode op, logic [7:0] nb, logic [31:0] nn);
        case ((words_sent / 120) % 4)
            0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            1: begin tx_idle_pct = 81; rx_stall_pct = 0;  end
            2: begin tx_idle_pct = 0;  rx_stall_pct = 81; end
            default: begin tx_idle_pct = 13; rx_stall_pct = 13; end
        endcase
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_opcode <= op;
        i_name_byte <= nb;
        i_nonce <= nn;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic noise_word();
        t_opcode op;
        op = t_opcode'($urandom_range(0, 3));
        send(op, 8'($urandom), $urandom);
    endtask

    // pull until the final packet byte shows up, with stray words mixed in
    task automatic drain_packet();
        int base, n;
        base = lasts_seen;
        n = 0;
        while (lasts_seen == base && n < 800) begin
            if ($urandom_range(0, 99) < 5) noise_word();
            send(OP_PULL, 8'($urandom), $urandom);
            n++;
        end
    endtask

    task automatic random_packet();
        int kind, n;
        logic [7:0] c;
        kind = $urandom_range(0, 99);
        if (kind < 85) n = $urandom_range(0, 24);
        else n = (kind < 91) ? $urandom_range(250, 262) : $urandom_range(60, 70);
        for (int i = 0; i < n; i++) begin
            if (kind >= 91) c = ($urandom_range(0, 9) == 0) ? 8'($urandom) : SEPARATOR;
            else if (kind >= 85) begin
                c = 8'($urandom);
                if (c == SEPARATOR) c = 8'h61;
            end else c = ($urandom_range(0, 3) == 0) ? SEPARATOR : 8'($urandom);
            send(OP_PUSH, c, $urandom);
        end
        if ($urandom_range(0, 19) == 0) noise_word();
        send(OP_FINISH, 8'($urandom), $urandom);
        drain_packet();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send(OP_PULL, 8'h00, '0);
        send(OP_NONE, 8'hff, '1);
        send(OP_PUSH, 8'h00, '0);
        send(OP_PUSH, SEPARATOR, '0);
        send(OP_PUSH, 8'hff, '0);
        send(OP_PUSH, SEPARATOR, '0);
        send(OP_PUSH, SEPARATOR, '0);
        send(OP_FINISH, 8'h00, 32'hffffffff);
        send(OP_PUSH, 8'h41, '0);
        send(OP_FINISH, 8'h00, 32'h12345678);
        send(OP_NONE, 8'h00, '0);
        drain_packet();
        send(OP_FINISH, 8'h00, 32'h00000000);
        drain_packet();

        while (words_sent < TARGET_WORDS) random_packet();

        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fails == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end
endmodule
